// File: rtl/core/led128_pkg.sv
// led128_pkg: shared types, tables and word packing helpers for the LED-128 encrypt core
// used by led128_round and led128_block_encrypt; no dependencies
package led128_pkg;

    localparam int LED_ROUNDS      = 48;
    localparam int ROUNDS_PER_STEP = 4;

    localparam logic [15:0] SIZE_CONST = 16'h3298;

    // four 16-bit column words, element i is word i
    typedef logic [3:0][15:0] words_t;

    // control that travels alongside each word in the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

    localparam logic [15:0] RC [LED_ROUNDS] = '{
        16'h1010, 16'h3030, 16'h7070, 16'h7171, 16'h7373, 16'h6767, 16'h5757, 16'h3737,
        16'h7676, 16'h7575, 16'h6363, 16'h4747, 16'h1717, 16'h3636, 16'h7474, 16'h6161,
        16'h5353, 16'h2727, 16'h5656, 16'h3535, 16'h6262, 16'h4545, 16'h0303, 16'h0606,
        16'h1414, 16'h2020, 16'h5050, 16'h3131, 16'h7272, 16'h6565, 16'h4343, 16'h0707,
        16'h1616, 16'h3434, 16'h6060, 16'h5151, 16'h3333, 16'h6666, 16'h5555, 16'h2323,
        16'h4646, 16'h1515, 16'h2222, 16'h4444, 16'h0101, 16'h1212, 16'h2424, 16'h4040
    };

    localparam logic [15:0] TAB0 [16] = '{
        16'hBDA5, 16'hA1E7, 16'hCF5B, 16'h597A, 16'h1C42, 16'h0000, 16'h72FE, 16'h9621,
        16'h6EBC, 16'hF89D, 16'hD319, 16'h37C6, 16'h8A63, 16'hE4DF, 16'h2B84, 16'h4538
    };
    localparam logic [15:0] TAB1 [16] = '{
        16'hB4EC, 16'hA3D5, 16'hC276, 16'h58FB, 16'h1739, 16'h0000, 16'h769A, 16'h9A8D,
        16'h61A3, 16'hFB2E, 16'hD54F, 16'h3958, 16'h8DB4, 16'hEC17, 16'h2E61, 16'h4FC2
    };
    localparam logic [15:0] TAB2 [16] = '{
        16'h819B, 16'h642A, 16'h49DC, 16'h3215, 16'hE5B1, 16'h0000, 16'hC847, 16'h7BC9,
        16'h2DF6, 16'h563F, 16'hAC6D, 16'h1FE3, 16'h9E78, 16'hB38E, 16'hFA52, 16'hD7A4
    };
    localparam logic [15:0] TAB3 [16] = '{
        16'hD6EB, 16'h1BDA, 16'hF37C, 16'h9CF5, 16'hCD31, 16'h0000, 16'h2597, 16'h6F89,
        16'hE8A6, 16'h872F, 16'h3E4D, 16'h7453, 16'hA2B8, 16'h4A1E, 16'hB962, 16'h51C4
    };

    // bytes to column words: low/high nibbles of even bytes, then of odd bytes
    function automatic words_t unpack_words(input logic [63:0] v);
        words_t w;
        for (int j = 0; j < 4; j++)
        begin
            w[0][4*j +: 4] = v[16*j      +: 4];
            w[1][4*j +: 4] = v[16*j + 4  +: 4];
            w[2][4*j +: 4] = v[16*j + 8  +: 4];
            w[3][4*j +: 4] = v[16*j + 12 +: 4];
        end
        return w;
    endfunction

    function automatic logic [63:0] pack_words(input words_t w);
        logic [63:0] v;
        for (int j = 0; j < 4; j++)
        begin
            v[16*j      +: 4] = w[0][4*j +: 4];
            v[16*j + 4  +: 4] = w[1][4*j +: 4];
            v[16*j + 8  +: 4] = w[2][4*j +: 4];
            v[16*j + 12 +: 4] = w[3][4*j +: 4];
        end
        return v;
    endfunction

    // sub cells, shift rows and mix columns folded into four lookups per word
    function automatic words_t mix_words(input words_t w);
        words_t t;
        for (int i = 0; i < 4; i++)
        begin
            t[i] = TAB0[w[i][3:0]]
                 ^ TAB1[w[(i + 1) & 3][7:4]]
                 ^ TAB2[w[(i + 2) & 3][11:8]]
                 ^ TAB3[w[(i + 3) & 3][15:12]];
        end
        return t;
    endfunction

endpackage

// File: rtl/core/led128_block_encrypt.sv
// led128_block_encrypt: top level of the LED-128 ECB encrypt core, 48-round pipeline
// depends on led128_pkg and led128_round
//
// usage
//   key: write key_low with cfg_index 0 and key_high with cfg_index 1 through
//   cfg_we/cfg_data; a write takes effect at the clock edge, no handshake.
//   keys are read by every round stage directly, so change them only while
//   no word is in flight (after the last done strobe).
//   input: a word (plain_block, block_last) is taken at each rising edge where
//   start is high and busy is low. busy is always low: a new word can be
//   started every cycle.
//   output: done is high for exactly one cycle together with cipher_block and
//   cipher_last. the receiver cannot hold results off, and nothing needs it to.
//   pipeline: one unpack stage, one stage per round for 48 rounds, and one
//   output stage with the final key add and repacking. throughput is one
//   word per cycle.
//   reset: rst_n low clears both keys to zero and drops all pipeline valid
//   bits; words in flight are discarded and no done pulse follows.
module led128_block_encrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] plain_block,
    input  logic        block_last,
    output logic        done,
    output logic [63:0] cipher_block,
    output logic        cipher_last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import led128_pkg::*;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // edges from acceptance to the edge that takes the result
    localparam int PIPE_LATENCY = LED_ROUNDS + 2;

    // key registers
    logic [63:0] key_low_reg;
    logic [63:0] key_low_next;
    logic [63:0] key_high_reg;
    logic [63:0] key_high_next;

    words_t key_low_w;
    words_t key_high_w;

    // input stage
    ctl_t   in_ctl_reg;
    ctl_t   in_ctl_next;
    words_t in_w_reg;

    // round chain, element 0 is the input stage
    ctl_t   ctl_chain [LED_ROUNDS + 1];
    words_t w_chain   [LED_ROUNDS + 1];

    // output stage
    logic        done_reg;
    logic [63:0] cipher_block_reg;
    logic        cipher_last_reg;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_next  = cfg_data;
                CFG_KEY_HIGH: key_high_next = cfg_data;
                default:      key_low_next  = key_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else
        begin
            key_low_reg  <= key_low_next;
            key_high_reg <= key_high_next;
        end
    end

    assign key_low_w  = unpack_words(key_low_reg);
    assign key_high_w = unpack_words(key_high_reg);

    // unpack the block into column words
    always_comb
    begin
        in_ctl_next.valid = accept;
        in_ctl_next.last  = block_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_w_reg <= unpack_words(plain_block);
    end

    assign ctl_chain[0] = in_ctl_reg;
    assign w_chain[0]   = in_w_reg;

    // one stage per round; the key goes in at the first round of each step,
    // key_low on even steps and key_high on odd steps
    for (genvar r = 0; r < LED_ROUNDS; r++)
    begin : g_round
        localparam int  STEP   = r / ROUNDS_PER_STEP;
        localparam logic KEY_EN = ((r % ROUNDS_PER_STEP) == 0);

        words_t step_key;

        if ((STEP % 2) == 0)
        begin : g_even
            assign step_key = key_low_w;
        end
        else
        begin : g_odd
            assign step_key = key_high_w;
        end

        led128_round u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[r]),
            .w_in    (w_chain[r]),
            .key_en  (KEY_EN),
            .key_w   (step_key),
            .rc      (RC[r]),
            .ctl_out (ctl_chain[r + 1]),
            .w_out   (w_chain[r + 1])
        );
    end

    // final whitening with key_low and repacking into bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_chain[LED_ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cipher_block_reg <= pack_words(w_chain[LED_ROUNDS] ^ key_low_w);
        cipher_last_reg  <= ctl_chain[LED_ROUNDS].last;
    end

    assign done         = done_reg;
    assign cipher_block = cipher_block_reg;
    assign cipher_last  = cipher_last_reg;

    // a result strobe always traces back to an accepted word a fixed latency ago
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LATENCY))
        else $error("done without a word accepted at the pipeline latency");

    // the framing flag travels with its word through all stages
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cipher_last == $past(block_last, PIPE_LATENCY)))
        else $error("cipher_last does not match block_last of its word");

    // a valid word at the last round stage sets the registered output strobe
    a_tail_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_chain[LED_ROUNDS].valid |=> done)
        else $error("valid word at the last round did not produce done");

endmodule

// File: rtl/core/led128_round.sv
// led128_round: one registered cipher round (optional key add, constants, table mix)
// depends on led128_pkg
module led128_round (
    input  logic              clk,
    input  logic              rst_n,
    input  led128_pkg::ctl_t   ctl_in,
    input  led128_pkg::words_t w_in,
    input  logic              key_en,
    input  led128_pkg::words_t key_w,
    input  logic [15:0]       rc,
    output led128_pkg::ctl_t   ctl_out,
    output led128_pkg::words_t w_out
);
    import led128_pkg::*;

    ctl_t   ctl_reg;
    words_t w_reg;
    words_t w_next;
    words_t x;

    always_comb
    begin
        x = key_en ? (w_in ^ key_w) : w_in;
        x[0] = x[0] ^ SIZE_CONST;
        x[1] = x[1] ^ rc;
        w_next = mix_words(x);
    end

    // control resets, payload does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    assign ctl_out = ctl_reg;
    assign w_out   = w_reg;

endmodule

// File: verif/led128_tb_pkg.sv
// led128_tb_pkg: key register indexes shared by the LED-128 testbench files
// used by led128_checker and tb; no dependencies
package led128_tb_pkg;

    localparam logic KEY_LOW_IDX  = 1'b0;
    localparam logic KEY_HIGH_IDX = 1'b1;

endpackage

// File: verif/led128_checker.sv
// led128_checker: watches the LED-128 encrypt ports, predicts each cipher word and compares
// depends on led128_tb_pkg for the key register indexes
module led128_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [63:0] plain_block,
    input  logic        block_last,
    input  logic        done,
    input  logic [63:0] cipher_block,
    input  logic        cipher_last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatches,
    output int          in_flight,
    output int          blocks_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import led128_tb_pkg::*;

    typedef logic [3:0][15:0] lanes_t;

    typedef struct packed {
        logic [63:0] block;
        logic        last;
    } cipher_word_t;

    localparam logic [15:0] SIZE_TAG = 16'h3298;

    localparam logic [0:47][15:0] RCON = {
        16'h1010, 16'h3030, 16'h7070, 16'h7171, 16'h7373, 16'h6767, 16'h5757, 16'h3737,
        16'h7676, 16'h7575, 16'h6363, 16'h4747, 16'h1717, 16'h3636, 16'h7474, 16'h6161,
        16'h5353, 16'h2727, 16'h5656, 16'h3535, 16'h6262, 16'h4545, 16'h0303, 16'h0606,
        16'h1414, 16'h2020, 16'h5050, 16'h3131, 16'h7272, 16'h6565, 16'h4343, 16'h0707,
        16'h1616, 16'h3434, 16'h6060, 16'h5151, 16'h3333, 16'h6666, 16'h5555, 16'h2323,
        16'h4646, 16'h1515, 16'h2222, 16'h4444, 16'h0101, 16'h1212, 16'h2424, 16'h4040
    };

    localparam logic [0:15][15:0] LUT0 = {
        16'hBDA5, 16'hA1E7, 16'hCF5B, 16'h597A, 16'h1C42, 16'h0000, 16'h72FE, 16'h9621,
        16'h6EBC, 16'hF89D, 16'hD319, 16'h37C6, 16'h8A63, 16'hE4DF, 16'h2B84, 16'h4538
    };
    localparam logic [0:15][15:0] LUT1 = {
        16'hB4EC, 16'hA3D5, 16'hC276, 16'h58FB, 16'h1739, 16'h0000, 16'h769A, 16'h9A8D,
        16'h61A3, 16'hFB2E, 16'hD54F, 16'h3958, 16'h8DB4, 16'hEC17, 16'h2E61, 16'h4FC2
    };
    localparam logic [0:15][15:0] LUT2 = {
        16'h819B, 16'h642A, 16'h49DC, 16'h3215, 16'hE5B1, 16'h0000, 16'hC847, 16'h7BC9,
        16'h2DF6, 16'h563F, 16'hAC6D, 16'h1FE3, 16'h9E78, 16'hB38E, 16'hFA52, 16'hD7A4
    };
    localparam logic [0:15][15:0] LUT3 = {
        16'hD6EB, 16'h1BDA, 16'hF37C, 16'h9CF5, 16'hCD31, 16'h0000, 16'h2597, 16'h6F89,
        16'hE8A6, 16'h872F, 16'h3E4D, 16'h7453, 16'hA2B8, 16'h4A1E, 16'hB962, 16'h51C4
    };

    logic [63:0]  key_lo = '0;
    logic [63:0]  key_hi = '0;
    cipher_word_t cipher_due [$];
    cipher_word_t oldest;

    initial
    begin
        mismatches     = 0;
        in_flight      = 0;
        blocks_checked = 0;
    end

    // even bytes feed lanes 0/1, odd bytes lanes 2/3, low nibble first
    function automatic lanes_t to_lanes(input logic [63:0] v);
        lanes_t     l;
        logic [7:0] b;
        l = '0;
        for (int k = 0; k < 8; k++)
        begin
            b = v[8*k +: 8];
            l[2*(k%2)][4*(k/2) +: 4]     = b[3:0];
            l[2*(k%2) + 1][4*(k/2) +: 4] = b[7:4];
        end
        return l;
    endfunction

    function automatic logic [63:0] from_lanes(input lanes_t l);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 8; k++)
            v[8*k +: 8] = {l[2*(k%2) + 1][4*(k/2) +: 4], l[2*(k%2)][4*(k/2) +: 4]};
        return v;
    endfunction

    function automatic lanes_t diffuse(input lanes_t l);
        lanes_t n;
        for (int c = 0; c < 4; c++)
            n[c] = LUT0[l[c][3:0]] ^ LUT1[l[(c+1)%4][7:4]]
                 ^ LUT2[l[(c+2)%4][11:8]] ^ LUT3[l[(c+3)%4][15:12]];
        return n;
    endfunction

    function automatic logic [63:0] led_encrypt(input logic [63:0] blk,
                                                input logic [63:0] klo,
                                                input logic [63:0] khi);
        lanes_t st;
        lanes_t k0;
        lanes_t k1;
        st = to_lanes(blk);
        k0 = to_lanes(klo);
        k1 = to_lanes(khi);
        for (int s = 0; s < 12; s++)
        begin
            st = st ^ ((s % 2 == 1) ? k1 : k0);
            for (int r = 0; r < 4; r++)
            begin
                st[0] = st[0] ^ SIZE_TAG;
                st[1] = st[1] ^ RCON[4*s + r];
                st    = diffuse(st);
            end
        end
        st = st ^ k0;
        return from_lanes(st);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            key_lo = '0;
            key_hi = '0;
            cipher_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    KEY_LOW_IDX:  key_lo = cfg_data;
                    KEY_HIGH_IDX: key_hi = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                oldest.block = led_encrypt(plain_block, key_lo, key_hi);
                oldest.last  = block_last;
                cipher_due.push_back(oldest);
            end
            if (done)
            begin
                if (cipher_due.size() == 0)
                begin
                    $error("done with no word pending, cipher_block %h", cipher_block);
                    mismatches++;
                end
                else
                begin
                    oldest = cipher_due.pop_front();
                    if (cipher_block !== oldest.block)
                    begin
                        $error("cipher_block: expected %h, got %h", oldest.block, cipher_block);
                        mismatches++;
                    end
                    if (cipher_last !== oldest.last)
                    begin
                        $error("cipher_last: expected %b, got %b", oldest.last, cipher_last);
                        mismatches++;
                    end
                    blocks_checked++;
                end
            end
        end
        in_flight = cipher_due.size();
    end

endmodule

// File: verif/tb.sv
// tb: stimulus and verdict for the LED-128 ECB encrypt core
// depends on led128_block_encrypt, led128_checker and led128_tb_pkg
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import led128_tb_pkg::*;

    // gap drawn before each word, in cycles
    localparam int MAX_GAP = 18;
    // long enough for done to come out of the full pipeline, plus margin
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 150;

    // edge patterns for the directed part
    localparam logic [0:5][63:0] EDGE_BLOCKS = {
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001
    };
    localparam logic [0:3][63:0] DIR_KEY_LO = {
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0
    };
    localparam logic [0:3][63:0] DIR_KEY_HI = {
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFEDC_BA98_7654_3210
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [63:0] plain_block = '0;
    logic        block_last  = 1'b0;
    logic        done;
    logic [63:0] cipher_block;
    logic        cipher_last;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = KEY_LOW_IDX;
    logic [63:0] cfg_data    = '0;

    int mismatches;
    int in_flight;
    int blocks_checked;
    int key_settings = 0;

    led128_block_encrypt uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .plain_block  (plain_block),
        .block_last   (block_last),
        .done         (done),
        .cipher_block (cipher_block),
        .cipher_last  (cipher_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // prediction and comparison live in the checker; the top only drives
    led128_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .plain_block    (plain_block),
        .block_last     (block_last),
        .done           (done),
        .cipher_block   (cipher_block),
        .cipher_last    (cipher_last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .in_flight      (in_flight),
        .blocks_checked (blocks_checked)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: the slowest legal run is well under a millisecond
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // pacing style per phase: no gaps, fully random gaps, or mostly back-to-back
    function automatic int draw_gap(input int pace);
        case (pace)
            0:       return 0;
            1:       return $urandom_range(0, MAX_GAP);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
        endcase
    endfunction

    // extremes now and then, otherwise a full random key half
    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly dense random blocks, some sparse, some with every bit set but one, some repeating one byte
    function automatic logic [63:0] pick_block();
        logic [63:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return one_hot;
            1:       return ~one_hot;
            2:       return {8{8'($urandom)}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // both key halves back to back; only called with nothing in flight
    task automatic program_keys(input logic [63:0] lo, input logic [63:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= KEY_LOW_IDX;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= KEY_HIGH_IDX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_settings++;
    endtask

    // idle for the drawn gap, then hold start until the word is taken
    task automatic send_word(input logic [63:0] blk, input logic lst, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        plain_block <= blk;
        block_last  <= lst;
        do
            @(posedge clk);
        while (busy);
    endtask

    // sample the checker away from the driving edge, then realign
    task automatic wait_drained();
        do
            @(negedge clk);
        while (in_flight != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          msg_len;
        int          pace;
        logic        lst;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edge patterns under reset keys first, then fixed key pairs, mostly extreme;
        // block_last alternates so framing is seen both ways
        for (int d = 0; d < 4; d++)
        begin
            if (d > 0)
                program_keys(DIR_KEY_LO[d], DIR_KEY_HI[d]);
            for (int p = 0; p < 6; p++)
                send_word(EDGE_BLOCKS[p], p[0], draw_gap(1));
            start <= 1'b0;
            // sender waits for every pending word before the next key change
            wait_drained();
        end

        // random phases: messages of 1 to 8 words ending in block_last,
        // with a few words whose last flag is flipped to break the framing
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_keys(pick_key(), pick_key());
            pace = $urandom_range(0, 2);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                msg_len = $urandom_range(1, 8);
                for (int i = 0; i < msg_len && sent < WORDS_PER_PHASE; i++)
                begin
                    lst = (i == msg_len - 1);
                    if ($urandom_range(0, 15) == 0)
                        lst = !lst;
                    send_word(pick_block(), lst, draw_gap(pace));
                    sent++;
                end
            end
            start <= 1'b0;
            wait_drained();
        end

        // let any stray done strobe show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d words encrypted and compared under %0d key settings",
                 blocks_checked, key_settings + 1);
        if (mismatches == 0 && in_flight == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
